// ----- rtl/spnp_pkg.sv -----
// Shared types and constants of the sorted priority node pool.
// Used by the top level; no dependencies.
`default_nettype none

package spnp_pkg;

   localparam int KEY_W  = 24;
   localparam int XY_W   = 12;
   localparam int IDX_W  = 10;
   localparam int MAXN_W = 11;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_SLOT,
      ST_POP_NODE,
      ST_INS_SCAN,
      ST_INS_HEAD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [XY_W-1:0]         x;
      logic [XY_W-1:0]         y;
      logic [IDX_W-1:0]        parent;
      logic                    has_parent;
      logic                    explored;
   } node_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] node_index;
      node_type         node;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/spnp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_node_pool_top.sv -----
// Sorted priority node pool: open list of a best-first search.
// Depends on spnp_pkg and spnp_ram.
//
// Usage
//   req_* : one operation word per handshake (op 0 clear, 1 insert, 2 pop).
//   rsp_* : exactly one result word per request, in request order.
//   csr_* : max_nodes, written whenever csr_wr_en is high; it is registered.
// Storage
//   Nodes live in a CAPACITY-entry RAM written at the next free index. The
//   open list is a circular array of node indexes in a second RAM, sorted by
//   ascending key from a head pointer, so a pop only advances the head.
// Timing
//   One request is in work at a time. Clear, refused insert, empty pop and
//   unused opcodes go straight to the done state; a pop reads the index RAM,
//   then the node RAM. An insert walks the open list from its tail at one
//   entry per cycle (index RAM read, node RAM read, compare, shift write).
// Stall and reset
//   A finished result waits in the response register; while rsp_ready is low
//   the next result waits in the block and no new request is taken.
//   Reset empties the pool and sets max_nodes to 1024. No clearing pass.
`default_nettype none

module sorted_priority_node_pool_top
   import spnp_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_op,
   input  wire logic signed [KEY_W-1:0] req_key,
   input  wire logic [XY_W-1:0]         req_pos_x,
   input  wire logic [XY_W-1:0]         req_pos_y,
   input  wire logic [IDX_W-1:0]        req_parent_index,
   input  wire logic                    req_parent_valid,
   input  wire logic                    req_explored,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [IDX_W-1:0]             rsp_node_index,
   output logic signed [KEY_W-1:0]      rsp_best_key,
   output logic [XY_W-1:0]              rsp_best_x,
   output logic [XY_W-1:0]              rsp_best_y,
   output logic [IDX_W-1:0]             rsp_best_parent,
   output logic                         rsp_best_has_parent,
   output logic                         rsp_best_explored,
   input  wire logic                    csr_wr_en,
   input  wire logic [MAXN_W-1:0]       csr_wr_data
);

   localparam int IW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int OO_DEPTH = 1 << IW;

   state_type        state_ff, state_in;
   logic [IW-1:0]    head_ff, head_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [CW-1:0]    open_ff, open_in;
   logic [MAXN_W-1:0] max_nodes_ff, max_nodes_in;
   logic [IW-1:0]    new_slot_ff, new_slot_in;
   logic signed [KEY_W-1:0] new_key_ff, new_key_in;
   logic [CW-1:0]    iss_left_ff, iss_left_in;
   logic             a_vld_ff, a_vld_in;
   logic [IW-1:0]    a_idx_ff, a_idx_in;
   logic             b_vld_ff, b_vld_in;
   logic [IW-1:0]    b_idx_ff, b_idx_in;
   logic [IW-1:0]    b_slot_ff, b_slot_in;
   result_type       res_ff, res_in;
   logic             rsp_vld_ff, rsp_vld_in;
   result_type       rsp_ff, rsp_in;

   logic             ins_full;
   logic             key_ge;
   logic [IW-1:0]    iss_idx;

   logic             oo_wr_en, oo_rd_en;
   logic [IW-1:0]    oo_wr_addr, oo_rd_addr, oo_wr_data, oo_rd_data;
   logic             ns_wr_en, ns_rd_en;
   logic [IW-1:0]    ns_wr_addr, ns_rd_addr;
   node_type         ns_wr_data, ns_rd_data;

   spnp_ram #(
      .WIDTH (IW),
      .DEPTH (OO_DEPTH)
   ) u_open_order (
      .clock   (clock),
      .wr_en   (oo_wr_en),
      .wr_addr (oo_wr_addr),
      .wr_data (oo_wr_data),
      .rd_en   (oo_rd_en),
      .rd_addr (oo_rd_addr),
      .rd_data (oo_rd_data)
   );

   spnp_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (CAPACITY)
   ) u_node_store (
      .clock   (clock),
      .wr_en   (ns_wr_en),
      .wr_addr (ns_wr_addr),
      .wr_data (ns_wr_data),
      .rd_en   (ns_rd_en),
      .rd_addr (ns_rd_addr),
      .rd_data (ns_rd_data)
   );

   assign ins_full = (32'(total_ff) >= 32'(max_nodes_ff)) ||
                     (32'(total_ff) >= CAPACITY) ||
                     (32'(open_ff) >= CAPACITY);
   assign key_ge   = $signed(ns_rd_data.key) >= $signed(new_key_ff);
   assign iss_idx  = IW'(iss_left_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         total_ff     <= '0;
         open_ff      <= '0;
         max_nodes_ff <= MAXN_W'(1024);
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         open_ff      <= open_in;
         max_nodes_ff <= max_nodes_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      new_slot_ff <= new_slot_in;
      new_key_ff  <= new_key_in;
      iss_left_ff <= iss_left_in;
      a_idx_ff    <= a_idx_in;
      b_idx_ff    <= b_idx_in;
      b_slot_ff   <= b_slot_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      open_in      = open_ff;
      max_nodes_in = max_nodes_ff;
      new_slot_in  = new_slot_ff;
      new_key_in   = new_key_ff;
      iss_left_in  = iss_left_ff;
      a_vld_in     = 1'b0;
      a_idx_in     = a_idx_ff;
      b_vld_in     = 1'b0;
      b_idx_in     = b_idx_ff;
      b_slot_in    = b_slot_ff;
      res_in       = res_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;

      oo_wr_en   = 1'b0;
      oo_wr_addr = '0;
      oo_wr_data = '0;
      oo_rd_en   = 1'b0;
      oo_rd_addr = '0;
      ns_wr_en   = 1'b0;
      ns_wr_addr = total_ff[IW-1:0];
      ns_wr_data = '{key: req_key, x: req_pos_x, y: req_pos_y,
                     parent: req_parent_index, has_parent: req_parent_valid,
                     explored: req_explored};
      ns_rd_en   = 1'b0;
      ns_rd_addr = '0;

      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (csr_wr_en) begin
         max_nodes_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in   = '{status: STAT_DONE, node_index: '0, node: '0};
               state_in = ST_DONE;
               unique case (req_op)
                  OP_CLEAR: begin
                     total_in = '0;
                     open_in  = '0;
                     head_in  = '0;
                  end
                  OP_INSERT: begin
                     if (ins_full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        ns_wr_en          = 1'b1;
                        new_slot_in       = total_ff[IW-1:0];
                        new_key_in        = req_key;
                        res_in.node_index = IDX_W'(total_ff[IW-1:0]);
                        total_in          = total_ff + CW'(1);
                        open_in           = open_ff + CW'(1);
                        iss_left_in       = open_ff;
                        state_in          = (open_ff == '0) ? ST_INS_HEAD : ST_INS_SCAN;
                     end
                  end
                  OP_POP: begin
                     if (open_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        // take the head entry, then drop it from the list
                        oo_rd_en   = 1'b1;
                        oo_rd_addr = head_ff;
                        head_in    = head_ff + IW'(1);
                        open_in    = open_ff - CW'(1);
                        state_in   = ST_POP_SLOT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP_SLOT: begin
            ns_rd_en          = 1'b1;
            ns_rd_addr        = oo_rd_data;
            res_in.node_index = IDX_W'(oo_rd_data);
            state_in          = ST_POP_NODE;
         end
         ST_POP_NODE: begin
            res_in.node = ns_rd_data;
            state_in    = ST_DONE;
         end
         ST_INS_SCAN: begin
            // compare stage: shift the entry up one place or drop the new index in
            if (b_vld_ff) begin
               oo_wr_en   = 1'b1;
               oo_wr_addr = head_ff + b_idx_ff + IW'(1);
               oo_wr_data = key_ge ? b_slot_ff : new_slot_ff;
               if (!key_ge) begin
                  state_in = ST_DONE;
               end else if (b_idx_ff == '0) begin
                  state_in = ST_INS_HEAD;
               end
            end
            if (state_in == ST_INS_SCAN) begin
               // issue stage: walk the list downward from the tail
               if (iss_left_ff != '0) begin
                  oo_rd_en    = 1'b1;
                  oo_rd_addr  = head_ff + iss_idx;
                  a_vld_in    = 1'b1;
                  a_idx_in    = iss_idx;
                  iss_left_in = iss_left_ff - CW'(1);
               end
               // node stage: fetch the key of the entry just read
               if (a_vld_ff) begin
                  ns_rd_en   = 1'b1;
                  ns_rd_addr = oo_rd_data;
                  b_vld_in   = 1'b1;
                  b_idx_in   = a_idx_ff;
                  b_slot_in  = oo_rd_data;
               end
            end
         end
         ST_INS_HEAD: begin
            oo_wr_en   = 1'b1;
            oo_wr_addr = head_ff;
            oo_wr_data = new_slot_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in = 1'b1;
               rsp_in     = res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_node_index      = rsp_ff.node_index;
   assign rsp_best_key        = rsp_ff.node.key;
   assign rsp_best_x          = rsp_ff.node.x;
   assign rsp_best_y          = rsp_ff.node.y;
   assign rsp_best_parent     = rsp_ff.node.parent;
   assign rsp_best_has_parent = rsp_ff.node.has_parent;
   assign rsp_best_explored   = rsp_ff.node.explored;

   a_open_le_total: assert property (@(posedge clock) disable iff (reset)
      open_ff <= total_ff)
      else $error("open count exceeds total count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_SCAN && b_vld_ff) |-> (32'(b_idx_ff) < 32'(open_ff)))
      else $error("insert scan index beyond open list");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_INSERT && !ins_full)
      |=> (32'(total_ff) == 32'($past(total_ff)) + 1))
      else $error("accepted insert did not advance total count");

   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.status != STAT_DONE) |-> (rsp_ff.node_index == '0))
      else $error("failed operation reports a node index");

endmodule

`default_nettype wire
